// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the decimator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("implication check failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/wbad_pkg.sv -----
// Shared constants, types and width functions of the waveform decimator.
package wbad_pkg;

   localparam int PIXELS_DEFAULT = 256;
   localparam int SAMPLE_BITS    = 24;
   localparam int FRAME_BITS     = 24;
   localparam int INDEX_BITS     = 8;
   localparam int MAG_BITS       = 24;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

   function automatic int spp_bits(int pixels);
      return FRAME_BITS - $clog2(pixels);
   endfunction

   function automatic int sum_bits(int pixels);
      return SAMPLE_BITS + spp_bits(pixels);
   endfunction

   function automatic int entry_bits(int pixels);
      return sum_bits(pixels) + spp_bits(pixels) + $clog2(pixels) + 1;
   endfunction

endpackage

// ----- hdl/wbad_front.sv -----
// Front end: frame register, sample accumulation and pixel group closing.
`include "assert_macros.svh"

module wbad_front #(
   parameter int PIXELS = wbad_pkg::PIXELS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_wr_en,
   input  logic [wbad_pkg::FRAME_BITS-1:0]             csr_wr_data,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0]     req_sample_value,
   input  logic                                        req_first_sample,
   output logic                                        push_valid,
   input  logic                                        push_ready,
   output logic [wbad_pkg::entry_bits(PIXELS)-1:0]     push_data
);
   import wbad_pkg::*;

   localparam int PIX_W = $clog2(PIXELS);
   localparam int SPP_W = spp_bits(PIXELS);
   localparam int SUM_W = sum_bits(PIXELS);

   logic [FRAME_BITS-1:0]   frame_ff, frame_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in, base_sum, acc_sum;
   logic [SPP_W-1:0]        cnt_ff, cnt_in, base_cnt, cnt_inc, spp;
   logic [PIX_W:0]          pix_ff, pix_in, base_pix;
   logic                    run, close, accept;

   assign spp       = frame_ff[FRAME_BITS-1:PIX_W];
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   assign base_sum = req_first_sample ? '0 : sum_ff;
   assign base_cnt = req_first_sample ? '0 : cnt_ff;
   assign base_pix = req_first_sample ? '0 : pix_ff;

   assign acc_sum = base_sum + SUM_W'(req_sample_value);
   assign cnt_inc = base_cnt + SPP_W'(1);
   assign run     = (spp != '0) && !base_pix[PIX_W];
   assign close   = run && (cnt_inc >= spp);

   assign push_valid = accept && close;
   assign push_data  = {acc_sum, spp, base_pix[PIX_W-1:0],
                        base_pix[PIX_W-1:0] == PIX_W'(PIXELS - 1)};

   always_comb begin
      frame_in = csr_wr_en ? csr_wr_data : frame_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      pix_in   = pix_ff;
      if (accept) begin
         priority if (close) begin
            sum_in = '0;
            cnt_in = '0;
            pix_in = base_pix + (PIX_W + 1)'(1);
         end else if (run) begin
            sum_in = acc_sum;
            cnt_in = cnt_inc;
            pix_in = base_pix;
         end else begin
            sum_in = base_sum;
            cnt_in = base_cnt;
            pix_in = base_pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         pix_ff   <= '0;
      end else begin
         frame_ff <= frame_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         pix_ff   <= pix_in;
      end
   end

   `ASSERT_NEXT(a_close_clears_group, push_valid && push_ready, cnt_ff == '0 && sum_ff == '0)
   `ASSERT_IMPL(a_pixel_bound, 1'b1, pix_ff <= (PIX_W + 1)'(PIXELS))

endmodule

// ----- hdl/wbad_queue.sv -----
// Two-entry queue between the accumulator and the divider.
`include "assert_macros.svh"

module wbad_queue #(
   parameter int WIDTH = wbad_pkg::entry_bits(wbad_pkg::PIXELS_DEFAULT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import wbad_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic [WIDTH-1:0] mem_in [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = in_data;
         wr_ptr_in         = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPL(a_queue_fill, 1'b1, count_ff <= 2'd2)
   `ASSERT_IMPL(a_queue_ptrs, count_ff == 2'd0 || count_ff == 2'd2, wr_ptr_ff == rd_ptr_ff)

endmodule

// ----- hdl/wbad_divider.sv -----
// Back end: serial restoring divider producing the pixel magnitude.
`include "assert_macros.svh"

module wbad_divider #(
   parameter int PIXELS = wbad_pkg::PIXELS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    pop_valid,
   output logic                                    pop_ready,
   input  logic [wbad_pkg::entry_bits(PIXELS)-1:0] pop_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [wbad_pkg::INDEX_BITS-1:0]         rsp_pixel_index,
   output logic [wbad_pkg::MAG_BITS-1:0]           rsp_magnitude,
   output logic                                    rsp_last_pixel
);
   import wbad_pkg::*;

   localparam int PIX_W   = $clog2(PIXELS);
   localparam int SPP_W   = spp_bits(PIXELS);
   localparam int SUM_W   = sum_bits(PIXELS);
   localparam int ENTRY_W = entry_bits(PIXELS);
   localparam int STEP_W  = $clog2(SUM_W);

   div_state_type     state_ff, state_in;
   logic [SUM_W-1:0]  n_ff, n_in, pop_abs;
   logic [SPP_W-1:0]  d_ff, d_in, rem_ff, rem_in, pop_spp;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PIX_W-1:0]  pix_ff, pix_in, pop_pix;
   logic              last_ff, last_in, pop_last;
   logic signed [SUM_W-1:0] pop_sum;
   logic [SPP_W:0]    rem_shift, diff;
   logic              ge, load, stepping, last_step;

   assign pop_sum  = pop_data[ENTRY_W-1 -: SUM_W];
   assign pop_spp  = pop_data[PIX_W + 1 +: SPP_W];
   assign pop_pix  = pop_data[1 +: PIX_W];
   assign pop_last = pop_data[0];
   assign pop_abs  = pop_sum[SUM_W-1] ? SUM_W'(-pop_sum) : SUM_W'(pop_sum);

   assign rem_shift = {rem_ff, n_ff[SUM_W-1]};
   assign diff      = rem_shift - {1'b0, d_ff};
   assign ge        = rem_shift >= {1'b0, d_ff};
   assign last_step = step_ff == STEP_W'(SUM_W - 1);
   assign load      = pop_valid && pop_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: state_in = pop_valid ? DIV_RUN : DIV_IDLE;
         DIV_RUN:  state_in = last_step ? DIV_HOLD : DIV_RUN;
         DIV_HOLD: begin
            if (rsp_ready) begin
               state_in = pop_valid ? DIV_RUN : DIV_IDLE;
            end
         end
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      rsp_valid = 1'b0;
      stepping  = 1'b0;
      unique case (state_ff)
         DIV_IDLE: pop_ready = 1'b1;
         DIV_RUN:  stepping  = 1'b1;
         DIV_HOLD: begin
            rsp_valid = 1'b1;
            pop_ready = rsp_ready;
         end
         default:  pop_ready = 1'b0;
      endcase
   end

   always_comb begin
      priority if (load) begin
         n_in    = pop_abs;
         d_in    = pop_spp;
         rem_in  = '0;
         step_in = '0;
         pix_in  = pop_pix;
         last_in = pop_last;
      end else if (stepping) begin
         n_in    = {n_ff[SUM_W-2:0], ge};
         d_in    = d_ff;
         rem_in  = ge ? diff[SPP_W-1:0] : rem_shift[SPP_W-1:0];
         step_in = step_ff + STEP_W'(1);
         pix_in  = pix_ff;
         last_in = last_ff;
      end else begin
         n_in    = n_ff;
         d_in    = d_ff;
         rem_in  = rem_ff;
         step_in = step_ff;
         pix_in  = pix_ff;
         last_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      pix_ff  <= pix_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff <= DIV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign rsp_pixel_index = INDEX_BITS'(pix_ff);
   assign rsp_magnitude   = n_ff[MAG_BITS-1:0];
   assign rsp_last_pixel  = last_ff;

   `ASSERT_IMPL(a_divisor_nonzero, state_ff == DIV_RUN, d_ff != '0)
   `ASSERT_IMPL(a_rem_below_divisor, state_ff == DIV_RUN, rem_ff < d_ff)

endmodule

// ----- hdl/waveform_block_average_decimator.sv -----
// Flow: a closing sample is written into the queue, loaded into the divider when it is free,
// divided step by step and given as a pixel; other samples give no transfer.
// Throughput: one sample per cycle while the queue has room; one group in the divider at a time.
// A two-entry queue between accumulator and divider absorbs short bursts of closing groups.
// Reset: synchronous, clears frame count, accumulator, counters, queue and divider state.
module waveform_block_average_decimator #(
   parameter int PIXELS = wbad_pkg::PIXELS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [wbad_pkg::FRAME_BITS-1:0]         csr_wr_data,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [wbad_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                    req_first_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [wbad_pkg::INDEX_BITS-1:0]         rsp_pixel_index,
   output logic [wbad_pkg::MAG_BITS-1:0]           rsp_magnitude,
   output logic                                    rsp_last_pixel
);
   import wbad_pkg::*;

   localparam int ENTRY_W = entry_bits(PIXELS);

   logic               push_valid, push_ready, pop_valid, pop_ready;
   logic [ENTRY_W-1:0] push_data, pop_data;

   wbad_front #(.PIXELS(PIXELS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_first_sample (req_first_sample),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   wbad_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   wbad_divider #(.PIXELS(PIXELS)) u_divider (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
